// ===== src/stepped_probe_slot_allocator_macros.svh =====
// Assertion helpers for the allocator control RTL.
// The checks compile away when SYNTHESIS is defined.
`ifndef STEPPED_PROBE_SLOT_ALLOCATOR_MACROS_SVH
`define STEPPED_PROBE_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is asserted
`define SPSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds across reset
`define SPSA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`else

`define SPSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPSA_ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

// ===== src/spsa_pkg.sv =====
package spsa_pkg;

  // Pool geometry
  localparam int SLOTS          = 1024;
  localparam int SLOT_W         = 10;
  localparam int POOLS          = 4;
  localparam int POOL_W         = 2;
  localparam int COUNT_W        = 11;

  // Request fields and limits
  localparam int MODE_W         = 2;
  localparam int SIZE_W         = 8;
  localparam int CHUNK_BYTES    = 64;

  // Probe stride register
  localparam int STEP_W         = 10;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(31);

  // Bitmap memory: one word holds the taken bits of WORD_W slots
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;
  localparam int WPP_W          = SLOT_W - BIT_W;
  localparam int WORDS_PER_POOL = SLOTS / WORD_W;
  localparam int MEM_AW         = POOL_W + WPP_W;
  localparam int MEM_DEPTH      = POOLS * WORDS_PER_POOL;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC,
    MODE_FREE,
    MODE_CLEAR,
    MODE_NOP
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_SIZE,
    ST_BAD_SLOT
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PROBE,
    S_FREE_CHK,
    S_CLEAR,
    S_RESULT
  } state_t;

  // One write port and one read port per cycle
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/spsa_in_if.sv =====
interface spsa_in_if;
  logic                         valid;
  logic                         ready;
  logic [spsa_pkg::MODE_W-1:0]  mode;
  logic [spsa_pkg::POOL_W-1:0]  pool_select;
  logic [spsa_pkg::SIZE_W-1:0]  request_size;
  logic [spsa_pkg::SLOT_W-1:0]  slot_index;

  modport source (
    output valid, mode, pool_select, request_size, slot_index,
    input  ready
  );

  modport sink (
    input  valid, mode, pool_select, request_size, slot_index,
    output ready
  );
endinterface

// ===== src/spsa_out_if.sv =====
interface spsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [spsa_pkg::SLOT_W-1:0]   granted_slot;
  logic [1:0]                    status;
  logic [spsa_pkg::COUNT_W-1:0]  used_count;

  modport source (
    output valid, granted_slot, status, used_count,
    input  ready
  );

  modport sink (
    input  valid, granted_slot, status, used_count,
    output ready
  );
endinterface

// ===== src/stepped_probe_slot_allocator.sv =====
// Allocate probes until a free slot is granted, up to 1023 occupied probes before the
// granted slot, and reports full after 1024 probes. One transaction in flight: the next
// is accepted only once the result is registered (output register free), and the probe
// walk reads one bitmap word a cycle.
// Reset: a sweep zeroes all 128 bitmap words, input not ready; counts clear, probe_step 31.
module stepped_probe_slot_allocator #(
  parameter int CHUNK_LIMIT = spsa_pkg::CHUNK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  spsa_in_if.sink                      in_ch,
  spsa_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [spsa_pkg::STEP_W-1:0]  cfg_wdata
);
  import spsa_pkg::*;

  logic [STEP_W-1:0] probe_step_r;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;

  // Probe stride register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_step_r <= STEP_RESET;
    end else if (cfg_we) begin
      probe_step_r <= cfg_wdata;
    end
  end

  spsa_ctrl #(
    .CHUNK_LIMIT (CHUNK_LIMIT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .probe_step (probe_step_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  spsa_bitmap_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ===== src/spsa_bitmap_mem.sv =====
module spsa_bitmap_mem (
  input  logic                         clk,
  input  spsa_pkg::mem_req_t           req,
  output logic [spsa_pkg::WORD_W-1:0] rd_data
);
  import spsa_pkg::*;

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/spsa_ctrl.sv =====
`include "stepped_probe_slot_allocator_macros.svh"

module spsa_ctrl #(
  parameter int CHUNK_LIMIT = spsa_pkg::CHUNK_BYTES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [spsa_pkg::STEP_W-1:0]  probe_step,
  spsa_in_if.sink                      in_ch,
  spsa_out_if.source                   out_ch,
  output spsa_pkg::mem_req_t           mem_req,
  input  logic [spsa_pkg::WORD_W-1:0]  rd_data
);
  import spsa_pkg::*;

  state_t              state_r, state_nxt;
  logic [MEM_AW-1:0]   sweep_r, sweep_nxt;
  logic [COUNT_W-1:0]  cnt_r [POOLS];
  logic [COUNT_W-1:0]  cnt_nxt [POOLS];
  logic                out_valid_r, out_valid_nxt;

  logic [POOL_W-1:0]   pool_r, pool_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic [SLOT_W:0]     probe_k_r, probe_k_nxt;
  logic [SLOT_W-1:0]   res_granted_r, res_granted_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   out_granted_r, out_granted_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                in_ready;
  logic [POOL_W-1:0]   in_pool;
  logic [SLOT_W-1:0]   pos_step;
  logic                probe_bit;
  logic                free_bit;

  assign in_pool   = in_ch.pool_select[POOL_W-1:0];
  assign pos_step  = pos_r + SLOT_W'(probe_step);
  assign probe_bit = rd_data[pos_r[BIT_W-1:0]];
  assign free_bit  = rd_data[slot_r[BIT_W-1:0]];

  // Next state, memory requests and result capture
  always_comb begin
    state_nxt       = state_r;
    sweep_nxt       = sweep_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    pool_nxt        = pool_r;
    slot_nxt        = slot_r;
    pos_nxt         = pos_r;
    probe_k_nxt     = probe_k_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    mem_req         = '0;
    in_ready        = 1'b0;

    // Output register drains independently of the sequencer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // Zero the whole bitmap after reset, one word a cycle
      S_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r;
        mem_req.wdata = '0;
        sweep_nxt     = sweep_r + MEM_AW'(1);
        if (sweep_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          pool_nxt        = in_pool;
          slot_nxt        = in_ch.slot_index;
          pos_nxt         = '0;
          probe_k_nxt     = '0;
          sweep_nxt       = '0;
          res_granted_nxt = '0;
          res_status_nxt  = ST_OK;
          unique case (mode_t'(in_ch.mode))
            MODE_ALLOC: begin
              if (in_ch.request_size > SIZE_W'(CHUNK_LIMIT)) begin
                res_status_nxt = ST_SIZE;
                state_nxt      = S_RESULT;
              end else begin
                // First probe is slot zero
                mem_req.re    = 1'b1;
                mem_req.raddr = {in_pool, {WPP_W{1'b0}}};
                state_nxt     = S_PROBE;
              end
            end
            MODE_FREE: begin
              if ({1'b0, in_ch.slot_index} >= (SLOT_W + 1)'(SLOTS)) begin
                res_status_nxt = ST_BAD_SLOT;
                state_nxt      = S_RESULT;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {in_pool, in_ch.slot_index[SLOT_W-1:BIT_W]};
                state_nxt     = S_FREE_CHK;
              end
            end
            MODE_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            MODE_NOP: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end

      // One probe per cycle: word for pos_r arrived, next read goes out now
      S_PROBE: begin
        if (!probe_bit) begin
          mem_req.we      = 1'b1;
          mem_req.waddr   = {pool_r, pos_r[SLOT_W-1:BIT_W]};
          mem_req.wdata   = rd_data | (WORD_W'(1) << pos_r[BIT_W-1:0]);
          cnt_nxt[pool_r] = cnt_r[pool_r] + COUNT_W'(1);
          res_granted_nxt = pos_r;
          state_nxt       = S_RESULT;
        end else if (probe_k_r == (SLOT_W + 1)'(SLOTS - 1)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESULT;
        end else begin
          pos_nxt       = pos_step;
          probe_k_nxt   = probe_k_r + (SLOT_W + 1)'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = {pool_r, pos_step[SLOT_W-1:BIT_W]};
        end
      end

      // Release only a slot that is actually taken
      S_FREE_CHK: begin
        if (!free_bit) begin
          res_status_nxt = ST_BAD_SLOT;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = {pool_r, slot_r[SLOT_W-1:BIT_W]};
          mem_req.wdata = rd_data & ~(WORD_W'(1) << slot_r[BIT_W-1:0]);
          if (cnt_r[pool_r] != '0) begin
            cnt_nxt[pool_r] = cnt_r[pool_r] - COUNT_W'(1);
          end
        end
        state_nxt = S_RESULT;
      end

      // Sweep the pool's words to zero
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {pool_r, sweep_r[WPP_W-1:0]};
        mem_req.wdata = '0;
        sweep_nxt     = sweep_r + MEM_AW'(1);
        if (sweep_r[WPP_W-1:0] == WPP_W'(WORDS_PER_POOL - 1)) begin
          cnt_nxt[pool_r] = '0;
          state_nxt       = S_RESULT;
        end
      end

      // Hand the transaction to the output register once it is free
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_status_nxt  = res_status_r;
          out_count_nxt   = cnt_r[pool_r];
          state_nxt       = S_IDLE;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      cnt_r       <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request context and result payload
  always_ff @(posedge clk) begin
    pool_r        <= pool_nxt;
    slot_r        <= slot_nxt;
    pos_r         <= pos_nxt;
    probe_k_r     <= probe_k_nxt;
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_slot = out_granted_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.used_count   = out_count_r;

  `SPSA_ASSERT(a_no_rw_same_word, clk, rst_n, (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr), "read and write hit the same bitmap word")
  `SPSA_ASSERT(a_one_at_a_time, clk, rst_n, (in_ch.valid && in_ready) |=> !in_ready, "second transaction accepted while busy")
  `SPSA_ASSERT(a_probe_bound, clk, rst_n, (state_r == S_PROBE) |-> (probe_k_r < (SLOT_W + 1)'(SLOTS)), "probe ran past the pool size")
  `SPSA_ASSERT(a_count_bound, clk, rst_n, (state_r == S_RESULT) |-> (cnt_r[pool_r] <= COUNT_W'(SLOTS)), "used count exceeds pool size")
  `SPSA_ASSERT_NORST(a_reset_init, clk, !rst_n |=> (state_r == S_INIT && !out_valid_r && !in_ready), "reset did not restart the bitmap sweep")

endmodule

// ===== bench/stepped_probe_slot_allocator_test.sv =====
`timescale 1ns / 1ps

module stepped_probe_slot_allocator_test;
  import spsa_pkg::*;

  localparam int unsigned BATCH_ITEMS = 60;
  localparam int unsigned BATCHES     = 18;
  localparam int unsigned HOLD_AT     = 300;   // result count that starts the long hold-off
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    mode_t             mode;
    logic [POOL_W-1:0] pool;
    logic [SIZE_W-1:0] size;
    logic [SLOT_W-1:0] slot;
  } slot_request_t;

  typedef struct {
    logic [SLOT_W-1:0]  granted;
    status_t            status;
    logic [COUNT_W-1:0] used;
  } slot_outcome_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;

  spsa_in_if  in_ch ();
  spsa_out_if out_ch ();

  stepped_probe_slot_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the allocator state
  bit                slot_taken [POOLS][SLOTS];
  int unsigned       pool_used [POOLS];
  logic [STEP_W-1:0] step_now;

  slot_request_t queued_requests [$];
  slot_outcome_t awaited_outcomes [$];
  slot_request_t cur_req;
  slot_outcome_t exp_out;

  int unsigned error_count;
  int unsigned results_seen;
  int unsigned hold_left;
  bit          calm;

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Expected outcome of one request; updates the shadow state
  function automatic slot_outcome_t pool_request_outcome(input slot_request_t r);
    slot_outcome_t o;
    int unsigned   p;
    int unsigned   s;
    o.granted = '0;
    o.status  = ST_OK;
    p = int'(r.pool) % POOLS;
    case (r.mode)
      MODE_ALLOC: begin
        if (r.size > CHUNK_BYTES) begin
          o.status = ST_SIZE;
        end else begin
          o.status = ST_FULL;
          for (int unsigned k = 0; k < SLOTS; k++) begin
            s = (k * step_now) % SLOTS;
            if (!slot_taken[p][s]) begin
              slot_taken[p][s] = 1'b1;
              pool_used[p]++;
              o.granted = SLOT_W'(s);
              o.status  = ST_OK;
              break;
            end
          end
        end
      end
      MODE_FREE: begin
        if (!slot_taken[p][r.slot]) begin
          o.status = ST_BAD_SLOT;
        end else begin
          slot_taken[p][r.slot] = 1'b0;
          if (pool_used[p] > 0) pool_used[p]--;
        end
      end
      MODE_CLEAR: begin
        for (int unsigned i = 0; i < SLOTS; i++) slot_taken[p][i] = 1'b0;
        pool_used[p] = 0;
      end
      default: ;
    endcase
    o.used = COUNT_W'(pool_used[p]);
    return o;
  endfunction

  task automatic push_request(input mode_t m, input int unsigned p, input int unsigned sz,
                              input int unsigned sl);
    slot_request_t r;
    r.mode = m;
    r.pool = POOL_W'(p);
    r.size = SIZE_W'(sz);
    r.slot = SLOT_W'(sl);
    queued_requests.push_back(r);
  endtask

  // Returns at a rising edge once no transaction is pending or outstanding
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_requests.size() != 0 || awaited_outcomes.size() != 0 || in_ch.valid);
  endtask

  // Only called while the block is idle
  task automatic write_probe_step(input logic [STEP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    step_now   = v;
  endtask

  // Mixed traffic: frees mostly hit slots that are taken when the batch is queued
  task automatic queue_random_batch(input int unsigned count);
    int unsigned pick;
    int unsigned p;
    int unsigned s;
    int unsigned start;
    repeat (count) begin
      pick = $urandom_range(99);
      p    = $urandom_range(POOLS - 1);
      if (pick < 46) begin
        if ($urandom_range(99) < 85)
          push_request(MODE_ALLOC, p, $urandom_range(CHUNK_BYTES), $urandom);
        else
          push_request(MODE_ALLOC, p, $urandom, $urandom);
      end else if (pick < 86) begin
        s = $urandom_range(SLOTS - 1);
        if ($urandom_range(99) < 80) begin
          start = $urandom_range(SLOTS - 1);
          for (int unsigned i = 0; i < SLOTS; i++) begin
            if (slot_taken[p][(start + i) % SLOTS]) begin
              s = (start + i) % SLOTS;
              break;
            end
          end
        end
        push_request(MODE_FREE, p, $urandom, s);
      end else if (pick < 91) begin
        push_request(MODE_CLEAR, p, $urandom, $urandom);
      end else begin
        push_request(MODE_NOP, p, $urandom, $urandom);
      end
    end
  endtask

  // Driver: one request per transaction, prediction taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        awaited_outcomes.push_back(pool_request_outcome(cur_req));
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          cur_req = queued_requests.pop_front();
          in_ch.mode         <= cur_req.mode;
          in_ch.pool_select  <= cur_req.pool;
          in_ch.request_size <= cur_req.size;
          in_ch.slot_index   <= cur_req.slot;
          in_ch.valid        <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left     = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (awaited_outcomes.size() == 0) begin
          $error("unexpected result: granted_slot %0d status %0d used_count %0d",
                 out_ch.granted_slot, out_ch.status, out_ch.used_count);
          error_count++;
        end else begin
          exp_out = awaited_outcomes.pop_front();
          if (out_ch.granted_slot !== exp_out.granted) begin
            $error("granted_slot: expected %0d, actual %0d", exp_out.granted,
                   out_ch.granted_slot);
            error_count++;
          end
          if (out_ch.status !== exp_out.status) begin
            $error("status: expected %0d, actual %0d", exp_out.status, out_ch.status);
            error_count++;
          end
          if (out_ch.used_count !== exp_out.used) begin
            $error("used_count: expected %0d, actual %0d", exp_out.used,
                   out_ch.used_count);
            error_count++;
          end
        end
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      // long hold-off lets the block back up into its input
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 38;
      end
    end
  end

  // Stimulus
  initial begin
    logic [STEP_W-1:0] step_pick;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    calm               = 1'b0;
    step_now           = STEP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: size limits, bad frees, unused mode, clear, default stride
    push_request(MODE_ALLOC, 0, 0, 0);
    push_request(MODE_ALLOC, 0, CHUNK_BYTES, SLOTS - 1);
    push_request(MODE_ALLOC, 0, CHUNK_BYTES + 1, 0);
    push_request(MODE_ALLOC, 3, 255, 0);
    push_request(MODE_ALLOC, 3, 1, 0);
    push_request(MODE_FREE, 0, 255, 31);
    push_request(MODE_FREE, 0, 0, 31);
    push_request(MODE_FREE, 1, 0, SLOTS - 1);
    push_request(MODE_FREE, 2, 0, 0);
    push_request(MODE_NOP, 0, 255, SLOTS - 1);
    push_request(MODE_CLEAR, 0, 255, SLOTS - 1);
    push_request(MODE_ALLOC, 0, CHUNK_BYTES, 0);
    push_request(MODE_FREE, 0, 0, 0);
    push_request(MODE_ALLOC, 2, 32, SLOTS - 1);
    wait_drained();

    // Zero stride: every probe lands on slot 0
    write_probe_step('0);
    push_request(MODE_ALLOC, 1, 0, 0);
    push_request(MODE_ALLOC, 1, 0, 0);
    push_request(MODE_FREE, 1, 0, 0);
    push_request(MODE_ALLOC, 1, 0, 0);
    push_request(MODE_CLEAR, 1, 0, 0);
    wait_drained();

    // Stride 512 reaches only two slots
    write_probe_step(STEP_W'(512));
    push_request(MODE_ALLOC, 2, 0, 0);
    push_request(MODE_ALLOC, 2, 0, 0);
    push_request(MODE_NOP, 3, 0, 0);
    wait_drained();

    // Largest stride
    write_probe_step('1);
    push_request(MODE_ALLOC, 3, 0, 0);
    push_request(MODE_ALLOC, 3, 0, 0);
    wait_drained();

    // Random batches, a new stride for each
    for (int unsigned b = 0; b < BATCHES; b++) begin
      case (b)
        0:       step_pick = STEP_RESET;
        1:       step_pick = STEP_W'(1);
        2:       step_pick = '1;
        3:       step_pick = '0;
        4:       step_pick = STEP_W'(512);
        5:       step_pick = STEP_W'(2);
        6:       step_pick = STEP_W'($urandom_range(511) * 2 + 2);
        default: step_pick = STEP_W'($urandom) | STEP_W'(1);
      endcase
      write_probe_step(step_pick);
      // a stretch with no idling on either side
      calm <= (b >= 9 && b <= 11);
      queue_random_batch(BATCH_ITEMS);
      wait_drained();
    end

    calm <= 1'b0;
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("** stepped_probe_slot_allocator: PASSED **");
    else
      $display("** stepped_probe_slot_allocator: FAILED **");
    $finish;
  end

  // Timeout
  initial begin
    #80_000_000;
    $display("** stepped_probe_slot_allocator: FAILED **");
    $finish;
  end

endmodule
